// ===== rtl/core/pipft_pkg.sv =====
// pipft_pkg: shared types and constants of the point-in-polygon fan test
// holds the request/response beat structs, the vertex word, the edge tag and the fsm states
// no dependencies
package pipft_pkg;

    localparam int MAX_VERTICES_DEF = 16;   // default depth of the vertex store
    localparam int COORD_W          = 16;   // signed q12.4 coordinate
    localparam int CNT_W            = 5;    // vertex count and edge counter
    localparam int SLOT_W           = 4;    // vertex_index field
    localparam int SECT_W           = 4;    // hit_sector field
    localparam int Q_W              = COORD_W + 1;  // center minus point

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [SLOT_W-1:0]         vertex_index;
        logic signed [COORD_W-1:0] vertex_dx;
        logic signed [COORD_W-1:0] vertex_dy;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } req_t;

    typedef struct packed {
        logic              inside_res;
        logic [SECT_W-1:0] hit_sector;
    } rsp_t;

    // one stored vertex offset
    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } vtx_t;

    // travels with an edge down the test pipeline
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [CNT_W-1:0] idx;
    } edge_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } st_t;

endpackage

// ===== rtl/core/pipft_edge_eval.sv =====
// pipft_edge_eval: two-stage triangle test for one fan edge per cycle
// stage one forms the six exact products, stage two the cross-product signs
// depends on pipft_pkg
module pipft_edge_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [pipft_pkg::Q_W-1:0]    qx,
    input  logic signed [pipft_pkg::Q_W-1:0]    qy,
    input  pipft_pkg::vtx_t                     a,
    input  pipft_pkg::vtx_t                     b,
    input  pipft_pkg::edge_tag_t                tag_in,
    output pipft_pkg::edge_tag_t                tag_out,
    output logic                                hit
);

    localparam int S_W = pipft_pkg::Q_W + 1;
    localparam int D_W = pipft_pkg::COORD_W + 1;
    localparam int P_W = S_W + D_W;
    localparam int X_W = P_W + 1;

    // true when the two values have strictly opposite signs
    function automatic logic opposite(input logic signed [X_W-1:0] x,
                                      input logic signed [X_W-1:0] y);
        logic x_neg;
        logic x_pos;
        logic y_neg;
        logic y_pos;
        x_neg = x[X_W-1];
        x_pos = !x[X_W-1] && (x != '0);
        y_neg = y[X_W-1];
        y_pos = !y[X_W-1] && (y != '0);
        return (x_neg && y_pos) || (x_pos && y_neg);
    endfunction

    logic signed [S_W-1:0] sx;
    logic signed [S_W-1:0] sy;
    logic signed [D_W-1:0] ex;
    logic signed [D_W-1:0] ey;

    logic signed [P_W-1:0] p1a_next, p1b_next, p2a_next, p2b_next, p3a_next, p3b_next;
    logic signed [P_W-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    pipft_pkg::edge_tag_t  tag_s1_reg;

    logic signed [X_W-1:0] d1, d2, d3;
    logic                  hit_next;
    pipft_pkg::edge_tag_t  tag_s2_reg;
    logic                  hit_reg;

    // vertex a = c + oa, b = c + ob, q = c - p
    always_comb
    begin
        sx = S_W'(qx) + S_W'(a.dx);
        sy = S_W'(qy) + S_W'(a.dy);
        ex = D_W'(b.dx) - D_W'(a.dx);
        ey = D_W'(b.dy) - D_W'(a.dy);
        p1a_next = P_W'(sx) * P_W'(ey);
        p1b_next = P_W'(ex) * P_W'(sy);
        p2a_next = P_W'(b.dx) * P_W'(qy);
        p2b_next = P_W'(b.dy) * P_W'(qx);
        p3a_next = P_W'(qx) * P_W'(a.dy);
        p3b_next = P_W'(a.dx) * P_W'(qy);
    end

    always_ff @(posedge clk)
    begin
        p1a_reg <= p1a_next;
        p1b_reg <= p1b_next;
        p2a_reg <= p2a_next;
        p2b_reg <= p2b_next;
        p3a_reg <= p3a_next;
        p3b_reg <= p3b_next;
    end

    always_comb
    begin
        d1 = X_W'(p1a_reg) - X_W'(p1b_reg);
        d2 = X_W'(p2a_reg) - X_W'(p2b_reg);
        d3 = X_W'(p3a_reg) - X_W'(p3b_reg);
        hit_next = !opposite(d1, d2) && !opposite(d2, d3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
        end
        else
        begin
            tag_s1_reg <= tag_in;
            tag_s2_reg <= tag_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign tag_out = tag_s2_reg;
    assign hit     = hit_reg;

endmodule

// ===== rtl/core/point_in_polygon_fan_test.sv =====
// point_in_polygon_fan_test: top level of the fan-triangle point-in-polygon test
// holds the vertex store, the walk sequencer and the result registers
// depends on pipft_pkg and pipft_edge_eval
//
// A load beat (kind 0) writes one vertex offset into slot vertex_index of the
// vertex store and gives no result; slots at or beyond MAX_VERTICES are
// dropped. A query beat (kind 1) brings the point and the polygon center,
// walks the fan edges 0..n-1 (n = vertex_count clamped to MAX_VERTICES, the
// last edge closing back to vertex 0) and returns exactly one result:
// inside_res and the first edge whose triangle holds the point. A query
// keeps busy high, and no new beat is taken, until its result has been
// shown; with n = 0 it answers without a walk. The walk uses the single
// read port of the store, which gives one vertex per cycle, then the read
// register and the two-stage product and sign pipeline; all edges are tested
// and the lowest hit wins. The result is shown for one cycle with done high
// and cannot be held off, so a receiver must take it then. vertex_count is
// written over the cfg channel, which is always ready; write it only while
// busy is low. Reading a slot that was never loaded gives an unspecified
// answer.
module point_in_polygon_fan_test #(
    parameter int MAX_VERTICES = pipft_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  pipft_pkg::req_t               req,
    // result strobe
    output logic                          done,
    output pipft_pkg::rsp_t               rsp,
    // vertex_count write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pipft_pkg::CNT_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = pipft_pkg::CNT_W;

    // configuration
    logic [CNT_W-1:0] vc_reg;
    logic [CNT_W-1:0] n_clamp;

    // sequencer
    pipft_pkg::st_t   st_reg, st_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic             accept;
    logic             accept_query;
    logic             rd_issue;
    logic             rd_en;

    // vertex store
    pipft_pkg::vtx_t  mem [MAX_VERTICES];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    pipft_pkg::vtx_t  rdata_reg;

    // read-data stage: k of the vertex now in rdata_reg
    logic             rv_reg;
    logic [CNT_W-1:0] rk_reg;

    // edge assembly
    pipft_pkg::vtx_t      v0_reg;
    pipft_pkg::vtx_t      prev_reg;
    pipft_pkg::vtx_t      ea_reg;
    pipft_pkg::vtx_t      eb_reg;
    pipft_pkg::edge_tag_t e_tag_reg;

    // query point relative to center
    logic signed [pipft_pkg::Q_W-1:0] qx_reg;
    logic signed [pipft_pkg::Q_W-1:0] qy_reg;

    // test pipeline outputs
    pipft_pkg::edge_tag_t h_tag;
    logic                 h_hit;

    // result
    logic                        found_reg;
    logic [pipft_pkg::SECT_W-1:0] sector_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= '0;
        else if (cfg_valid && cfg_ready)
            vc_reg <= cfg_data;
    end

    // counts above the store depth act as the full store
    assign n_clamp = (32'(vc_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vc_reg;

    assign accept       = start && !busy;
    assign accept_query = accept && (req.kind == pipft_pkg::KIND_QUERY);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            pipft_pkg::ST_IDLE:
            begin
                if (accept_query)
                    st_next = (n_clamp == '0) ? pipft_pkg::ST_DONE : pipft_pkg::ST_READ;
            end
            pipft_pkg::ST_READ:
            begin
                if (k_reg == n_reg)
                    st_next = pipft_pkg::ST_DRAIN;
            end
            pipft_pkg::ST_DRAIN:
            begin
                if (h_tag.vld && h_tag.last)
                    st_next = pipft_pkg::ST_DONE;
            end
            pipft_pkg::ST_DONE:
                st_next = pipft_pkg::ST_IDLE;
            default:
                st_next = pipft_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy     = (st_reg != pipft_pkg::ST_IDLE);
        done     = (st_reg == pipft_pkg::ST_DONE);
        rd_issue = (st_reg == pipft_pkg::ST_READ);
        // k == n is the closing step, it reuses vertex 0 and needs no read
        rd_en    = rd_issue && (k_reg < n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= pipft_pkg::ST_IDLE;
            n_reg  <= '0;
            k_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept_query)
            begin
                n_reg <= n_clamp;
                k_reg <= '0;
            end
            else if (rd_issue)
                k_reg <= k_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_query)
        begin
            qx_reg <= pipft_pkg::Q_W'(req.center_x) - pipft_pkg::Q_W'(req.point_x);
            qy_reg <= pipft_pkg::Q_W'(req.center_y) - pipft_pkg::Q_W'(req.point_y);
        end
    end

    // store: writes only happen while idle, reads only while walking, so a
    // read never meets a write to the same slot
    assign wr_en   = accept && (req.kind == pipft_pkg::KIND_LOAD) &&
                     (32'(req.vertex_index) < MAX_VERTICES);
    assign wr_addr = IDX_W'(req.vertex_index);
    assign rd_addr = IDX_W'(k_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= '{dx: req.vertex_dx, dy: req.vertex_dy};
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // read-data stage bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            rk_reg    <= '0;
            e_tag_reg <= '0;
        end
        else
        begin
            rv_reg        <= rd_issue;
            rk_reg        <= k_reg;
            e_tag_reg.vld <= rv_reg && (rk_reg != '0);
            e_tag_reg.last <= (rk_reg == n_reg);
            e_tag_reg.idx <= rk_reg - CNT_W'(1);
        end
    end

    // edge k-1 pairs the previous vertex with this one; the closing edge
    // pairs the last vertex with vertex 0
    always_ff @(posedge clk)
    begin
        if (rv_reg)
        begin
            if (rk_reg == '0)
                v0_reg <= rdata_reg;
            prev_reg <= rdata_reg;
            ea_reg   <= prev_reg;
            eb_reg   <= (rk_reg == n_reg) ? v0_reg : rdata_reg;
        end
    end

    pipft_edge_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .a       (ea_reg),
        .b       (eb_reg),
        .tag_in  (e_tag_reg),
        .tag_out (h_tag),
        .hit     (h_hit)
    );

    // first hit in edge order wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (accept_query)
            found_reg <= 1'b0;
        else if (h_tag.vld && h_hit)
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept_query)
            sector_reg <= '0;
        else if (h_tag.vld && h_hit && !found_reg)
            sector_reg <= h_tag.idx[pipft_pkg::SECT_W-1:0];
    end

    assign rsp.inside_res = found_reg;
    assign rsp.hit_sector = sector_reg;

endmodule

// ===== rtl/core/pipft_chk.sv =====
// pipft_chk: port-level checks of the fan test, attached by bind
// watches the command, busy and result strobe behavior over time
// depends on pipft_pkg and point_in_polygon_fan_test
module pipft_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input pipft_pkg::req_t req,
    input logic            done,
    input pipft_pkg::rsp_t rsp
);

    // a result only appears while a query is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a query");

    // one result per query: the strobe ends the query
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("result strobe not followed by idle");

    // an accepted query always occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.kind == pipft_pkg::KIND_QUERY) |=> busy)
        else $error("query accepted without going busy");

    // a load gives no result and leaves the block idle
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.kind == pipft_pkg::KIND_LOAD) |=> !busy && !done)
        else $error("load beat disturbed the sequencer");

    // an outside answer reports sector zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.inside_res |-> (rsp.hit_sector == '0))
        else $error("outside result with nonzero sector");

endmodule

bind point_in_polygon_fan_test pipft_chk u_pipft_chk (.*);

// ===== sim/pipft_fan_checker.sv =====
`timescale 1ns / 100ps
// pipft_fan_checker: watches the command, result and vertex_count channels of
// point_in_polygon_fan_test, predicts each query answer and compares it
// depends on pipft_pkg for the beat structs and the kind codes
module pipft_fan_checker
    import pipft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  req_t             req,
    input  logic             done,
    input  rsp_t             rsp,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    output int               mismatches,
    output int               pending
);

    logic signed [COORD_W-1:0] offs_x [MAX_VERTICES_DEF];
    logic signed [COORD_W-1:0] offs_y [MAX_VERTICES_DEF];
    logic [CNT_W-1:0]          vertex_count_q;
    rsp_t                      answers_due [$];

    function automatic bit strictly_opposite(input longint a, input longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // sign term of point p against segment a -> b
    function automatic longint side_of(input longint px, input longint py,
                                       input longint ax, input longint ay,
                                       input longint bx, input longint by);
        return (ax - px) * (by - ay) - (bx - ax) * (ay - py);
    endfunction

    // walks the fan, first triangle holding the point wins
    function automatic rsp_t fan_verdict(input logic signed [COORD_W-1:0] px,
                                         input logic signed [COORD_W-1:0] py,
                                         input logic signed [COORD_W-1:0] cx,
                                         input logic signed [COORD_W-1:0] cy);
        rsp_t   r;
        int     n;
        int     j;
        longint ax, ay, bx, by, d1, d2, d3;
        r = '0;
        n = (vertex_count_q > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vertex_count_q);
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            ax = longint'(offs_x[i]) + longint'(cx);
            ay = longint'(offs_y[i]) + longint'(cy);
            bx = longint'(offs_x[j]) + longint'(cx);
            by = longint'(offs_y[j]) + longint'(cy);
            d1 = side_of(px, py, ax, ay, bx, by);
            d2 = side_of(px, py, bx, by, cx, cy);
            d3 = side_of(px, py, cx, cy, ax, ay);
            if (!r.inside_res && !strictly_opposite(d1, d2) && !strictly_opposite(d2, d3))
            begin
                r.inside_res = 1'b1;
                r.hit_sector = i[SECT_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t due;
        if (!rst_n)
        begin
            vertex_count_q = '0;
            answers_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result beat with no query waiting: inside_res %0d hit_sector %0d",
                           rsp.inside_res, rsp.hit_sector);
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (rsp.inside_res !== due.inside_res)
                    begin
                        $error("inside_res: expected %0d, got %0d", due.inside_res,
                               rsp.inside_res);
                        mismatches++;
                    end
                    if (rsp.hit_sector !== due.hit_sector)
                    begin
                        $error("hit_sector: expected %0d, got %0d", due.hit_sector,
                               rsp.hit_sector);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                vertex_count_q = cfg_data;
            if (start && !busy)
            begin
                if (req.kind == KIND_LOAD)
                begin
                    offs_x[req.vertex_index] = req.vertex_dx;
                    offs_y[req.vertex_index] = req.vertex_dy;
                end
                else
                    answers_due.push_back(fan_verdict(req.point_x, req.point_y,
                                                      req.center_x, req.center_y));
            end
        end
        pending = answers_due.size();
    end

endmodule

// ===== sim/point_in_polygon_fan_test_test.sv =====
`timescale 1ns / 100ps
// point_in_polygon_fan_test_test: stimulus and verdict for the fan point-in-polygon block
// depends on pipft_pkg, point_in_polygon_fan_test and pipft_fan_checker
module point_in_polygon_fan_test_test;

    import pipft_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    req_t             req = '0;
    logic             done;
    rsp_t             rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    int               mismatches;
    int               pending;

    // vertex offsets as last loaded, used only to aim query points at the polygon
    int sh_dx [MAX_VERTICES_DEF];
    int sh_dy [MAX_VERTICES_DEF];
    // vertex count in effect, after clamping to the store depth
    int cur_n = 0;

    // cos of k * 22.5 degrees at full q12.4 scale, so both extremes show up
    int ring [16] = '{32767, 30273, 23170, 12539, 0, -12539, -23170, -30273,
                      -32768, -30273, -23170, -12539, 0, 12539, 23170, 30273};

    // vertex_count sets run in the random part, extremes first
    int phase_counts [7] = '{0, 1, 2, 17, 31, 16, 3};

    always #5 clk = ~clk;

    point_in_polygon_fan_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pipft_fan_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // signed value spread evenly over -lim .. lim
    function automatic int srand(input int lim);
        return int'($urandom_range(2 * lim, 0)) - lim;
    endfunction

    // load beat, the unused query fields carry noise
    function automatic req_t load_beat(input int slot, input int dx, input int dy);
        req_t r;
        r              = '0;
        r.kind         = KIND_LOAD;
        r.vertex_index = slot[SLOT_W-1:0];
        r.vertex_dx    = dx[COORD_W-1:0];
        r.vertex_dy    = dy[COORD_W-1:0];
        r.point_x      = COORD_W'($urandom);
        r.point_y      = COORD_W'($urandom);
        r.center_x     = COORD_W'($urandom);
        r.center_y     = COORD_W'($urandom);
        sh_dx[slot]    = int'(r.vertex_dx);
        sh_dy[slot]    = int'(r.vertex_dy);
        return r;
    endfunction

    // query beat, the unused load fields carry noise
    function automatic req_t query_beat(input int px, input int py, input int cx, input int cy);
        req_t r;
        r              = '0;
        r.kind         = KIND_QUERY;
        r.vertex_index = SLOT_W'($urandom);
        r.vertex_dx    = COORD_W'($urandom);
        r.vertex_dy    = COORD_W'($urandom);
        r.point_x      = px[COORD_W-1:0];
        r.point_y      = py[COORD_W-1:0];
        r.center_x     = cx[COORD_W-1:0];
        r.center_y     = cy[COORD_W-1:0];
        return r;
    endfunction

    // hold the beat on the command port until the block takes it; start stays
    // high afterwards so back-to-back beats need no fresh edge on it
    task automatic issue(input req_t r);
        start = 1'b1;
        req   = r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // vertex_count may only change with the block idle: drain every answer,
    // then give the walk time to finish before the write beat
    task automatic program_count(input int v);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (MAX_VERTICES_DEF + 8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_n     = (v > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : v;
    endtask

    initial
    begin
        int pick;
        int k;
        int k1;
        int cx;
        int cy;
        int px;
        int py;
        int dx;
        int dy;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // empty polygon: always outside, the store is not touched yet
        program_count(0);
        issue(query_beat(0, 0, 0, 0));
        issue(query_beat(32767, -32768, -32768, 32767));

        // fill every slot with a 16-gon touching the coordinate extremes, so no
        // later query can read a slot that was never loaded
        for (int i = 0; i < MAX_VERTICES_DEF; i++)
            issue(load_beat(i, ring[i], ring[(i + 12) % 16]));

        // count above the store depth acts as a full store
        program_count(31);
        issue(query_beat(0, 0, 0, 0));
        issue(query_beat(100, 50, 0, 0));
        issue(query_beat(32767, 32767, -32768, -32768));

        // single vertex: its only edge runs from vertex 0 back to itself
        program_count(1);
        issue(query_beat(5, 5, 5, 5));
        issue(query_beat(200, -300, 0, 0));

        // far corner against a far center, widest differences and products
        program_count(16);
        issue(query_beat(-32768, -32768, 32767, 32767));

        // --- random part ---
        // mostly queries aimed into the current polygon, loads reshape it as we go
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 7)
                program_count(phase_counts[ph]);
            else if ($urandom_range(2, 0) == 0)
                program_count($urandom_range(31, 0));
            else
                program_count($urandom_range(16, 3));

            repeat (146)
            begin
                // sender gaps in bursts, none in the last two phases
                if (ph < 10 && $urandom_range(3, 0) == 0)
                begin
                    start = 1'b0;
                    repeat ($urandom_range(9, 1)) @(negedge clk);
                end

                if ($urandom_range(3, 0) == 0)
                begin
                    // load beat: small shapes, full range, or pinned to the extremes
                    pick = $urandom_range(99, 0);
                    if (pick < 60)
                    begin
                        dx = srand(8000);
                        dy = srand(8000);
                    end
                    else if (pick < 85)
                    begin
                        dx = srand(32767);
                        dy = srand(32767);
                    end
                    else
                    begin
                        dx = $urandom_range(1, 0) ? 32767 : -32768;
                        dy = $urandom_range(1, 0) ? 32767 : -32768;
                    end
                    issue(load_beat($urandom_range(15, 0), dx, dy));
                end
                else
                begin
                    // pick an edge of the active fan to aim at
                    k  = (cur_n == 0) ? 0 : $urandom_range(cur_n - 1, 0);
                    k1 = (k + 1 >= cur_n) ? 0 : k + 1;

                    pick = $urandom_range(99, 0);
                    if (pick < 60)
                    begin
                        cx = srand(4096);
                        cy = srand(4096);
                    end
                    else if (pick < 85)
                    begin
                        cx = srand(32767);
                        cy = srand(32767);
                    end
                    else
                    begin
                        cx = $urandom_range(1, 0) ? 32767 : -32768;
                        cy = $urandom_range(1, 0) ? 32767 : -32768;
                    end

                    pick = $urandom_range(99, 0);
                    if (pick < 40)
                    begin
                        // near the center, inside or just outside
                        px = cx + srand(6000);
                        py = cy + srand(6000);
                    end
                    else if (pick < 60)
                    begin
                        // well inside the triangle of the chosen edge
                        px = cx + (sh_dx[k] + sh_dx[k1]) / 3;
                        py = cy + (sh_dy[k] + sh_dy[k1]) / 3;
                    end
                    else if (pick < 70)
                    begin
                        // on the center, all fan triangles touch here
                        px = cx;
                        py = cy;
                    end
                    else if (pick < 80)
                    begin
                        // on a vertex
                        px = cx + sh_dx[k];
                        py = cy + sh_dy[k];
                    end
                    else
                    begin
                        px = srand(32767);
                        py = srand(32767);
                    end
                    issue(query_beat(px, py, cx, cy));
                end
            end
        end

        // drain, then a quiet stretch to catch any stray result beat
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (MAX_VERTICES_DEF + 14) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
